@@ hw/rtl/mqts_pkg.sv @@
// Shared request and sequencer state codes for the two-stack maximum queue.
package mqts_pkg;

  // Request codes carried on the action port.
  localparam logic [1:0] ACT_ENQUEUE = 2'd0;
  localparam logic [1:0] ACT_DEQUEUE = 2'd1;
  localparam logic [1:0] ACT_MAXIMUM = 2'd2;
  localparam logic [1:0] ACT_EMPTY   = 2'd3;

  // Sequencer state codes.
  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_XFER   = 2'd1;
  localparam logic [1:0] ST_POP    = 2'd2;
  localparam logic [1:0] ST_REFILL = 2'd3;

endpackage

@@ hw/rtl/max_queue_two_stack.sv @@
// Top level of the first-in first-out queue with maximum, built from two stacks.
//
// A request is taken at a rising edge where start is high and busy is low.
// action selects enqueue, dequeue, maximum query or empty query; value is
// the item to enqueue. Every request gives exactly one result: done is high
// for one cycle with data, is_empty and error, and the receiver cannot stall.
// For enqueue, maximum and empty queries the result comes in the cycle after
// the request is taken. A dequeue from a non-empty output stack also answers
// in the next cycle; when that stack holds two or more items, busy stays high
// after the pop while the cached top entry is reloaded from the entry below.
// A dequeue that finds the output stack empty first moves the input stack
// across, one item a cycle through the input stack memory read port. The
// pop and its result follow the transfer, and the next request can be taken
// once the cached top entry is reloaded, with no reload when only one item
// was moved. Each item is moved across only once. The input stack memory
// stores only values; its running maximum at the top is held in a register.
// Reset clears the heights and the item count; the memories are not cleared
// and need no clearing pass. An enqueue while DEPTH items are held is dropped
// and flagged with error, as are dequeue and maximum on an empty queue.
module max_queue_two_stack #(
  parameter int DEPTH      = 1024,
  parameter int DATA_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         action,
  input  logic signed [31:0] value,
  output logic               done,
  output logic signed [31:0] data,
  output logic               is_empty,
  output logic               error
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int DW = DATA_WIDTH;

  logic [1:0]           state;
  logic [CW-1:0]        in_h;
  logic [CW-1:0]        out_h;
  logic [CW-1:0]        count;
  logic signed [DW-1:0] in_top_max;
  logic signed [DW-1:0] out_top_val;
  logic signed [DW-1:0] out_top_max;

  logic                 accept;
  logic                 full;
  logic                 pop_now;
  logic                 xfer_start;
  logic [CW-1:0]        in_h_m1;
  logic [CW-1:0]        out_h_m2;
  logic signed [DW-1:0] v_dw;
  logic signed [DW-1:0] push_max;
  logic signed [DW-1:0] xfer_v;
  logic signed [DW-1:0] xfer_max;
  logic signed [DW-1:0] max_all;

  logic                 in_we;
  logic                 in_re;
  logic [DW-1:0]        in_rdata;
  logic                 out_we;
  logic                 out_re;
  logic [2*DW-1:0]      out_wdata;
  logic [2*DW-1:0]      out_rdata;

  assign busy   = (state != mqts_pkg::ST_IDLE);
  assign accept = start && !busy;
  assign full   = (count == CW'(DEPTH));

  // Incoming item held at the stack width.
  assign v_dw     = DW'(value);
  assign push_max = (in_h == '0 || v_dw > in_top_max) ? v_dw : in_top_max;

  // Item arriving from the input stack during a transfer.
  assign xfer_v   = $signed(in_rdata);
  assign xfer_max = (out_h == '0 || xfer_v > out_top_max) ? xfer_v : out_top_max;

  // Current maximum over both stack tops.
  always_comb begin
    if (in_h != '0 && out_h != '0) begin
      max_all = (in_top_max > out_top_max) ? in_top_max : out_top_max;
    end else if (in_h != '0) begin
      max_all = in_top_max;
    end else begin
      max_all = out_top_max;
    end
  end

  // Pop happens straight from idle, or after a transfer has finished.
  assign pop_now = (accept && action == mqts_pkg::ACT_DEQUEUE && count != '0 &&
                    out_h != '0) || (state == mqts_pkg::ST_POP);
  assign xfer_start = accept && action == mqts_pkg::ACT_DEQUEUE && count != '0 &&
                      out_h == '0;

  assign in_h_m1  = in_h - CW'(1);
  assign out_h_m2 = out_h - CW'(2);

  // Memory port control.
  assign in_we     = accept && action == mqts_pkg::ACT_ENQUEUE && !full;
  assign in_re     = xfer_start || (state == mqts_pkg::ST_XFER && in_h != '0);
  assign out_we    = (state == mqts_pkg::ST_XFER);
  assign out_wdata = {xfer_v, xfer_max};
  assign out_re    = pop_now && out_h >= CW'(2);

  mqts_stack_ram #(
    .DEPTH (DEPTH),
    .WIDTH (DW)
  ) u_in_ram (
    .clk   (clk),
    .we    (in_we),
    .waddr (in_h[AW-1:0]),
    .wdata (v_dw),
    .re    (in_re),
    .raddr (in_h_m1[AW-1:0]),
    .rdata (in_rdata)
  );

  mqts_stack_ram #(
    .DEPTH (DEPTH),
    .WIDTH (2 * DW)
  ) u_out_ram (
    .clk   (clk),
    .we    (out_we),
    .waddr (out_h[AW-1:0]),
    .wdata (out_wdata),
    .re    (out_re),
    .raddr (out_h_m2[AW-1:0]),
    .rdata (out_rdata)
  );

  // Sequencer, stack heights and cached stack tops.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mqts_pkg::ST_IDLE;
      in_h  <= '0;
      out_h <= '0;
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        mqts_pkg::ST_IDLE: begin
          if (accept) begin
            case (action)
              mqts_pkg::ACT_ENQUEUE: begin
                done     <= 1'b1;
                data     <= '0;
                is_empty <= 1'b0;
                error    <= full;
                if (!full) begin
                  in_top_max <= push_max;
                  in_h       <= in_h + CW'(1);
                  count      <= count + CW'(1);
                end
              end
              mqts_pkg::ACT_DEQUEUE: begin
                if (count == '0) begin
                  done     <= 1'b1;
                  data     <= '0;
                  is_empty <= 1'b1;
                  error    <= 1'b1;
                end else if (out_h == '0) begin
                  in_h  <= in_h_m1;
                  state <= mqts_pkg::ST_XFER;
                end
              end
              mqts_pkg::ACT_MAXIMUM: begin
                done     <= 1'b1;
                data     <= (count == '0) ? '0 : 32'(max_all);
                is_empty <= (count == '0);
                error    <= (count == '0);
              end
              default: begin
                done     <= 1'b1;
                data     <= '0;
                is_empty <= (count == '0);
                error    <= 1'b0;
              end
            endcase
          end
        end
        mqts_pkg::ST_XFER: begin
          out_top_val <= xfer_v;
          out_top_max <= xfer_max;
          out_h       <= out_h + CW'(1);
          if (in_h != '0) begin
            in_h <= in_h_m1;
          end else begin
            state <= mqts_pkg::ST_POP;
          end
        end
        mqts_pkg::ST_REFILL: begin
          out_top_val <= $signed(out_rdata[2*DW-1:DW]);
          out_top_max <= $signed(out_rdata[DW-1:0]);
          state       <= mqts_pkg::ST_IDLE;
        end
        default: begin
          // Pop is handled below.
        end
      endcase

      // Pop of the output stack top; the entry below is reloaded if present.
      if (pop_now) begin
        done     <= 1'b1;
        data     <= 32'(out_top_val);
        is_empty <= (count == CW'(1));
        error    <= 1'b0;
        count    <= count - CW'(1);
        out_h    <= out_h - CW'(1);
        state    <= (out_h >= CW'(2)) ? mqts_pkg::ST_REFILL : mqts_pkg::ST_IDLE;
      end
    end
  end

  // The item count matches both heights, with one item in flight while moving.
  a_count_idle: assert property (@(posedge clk) disable iff (rst)
    (state != mqts_pkg::ST_XFER) |-> (count == in_h + out_h))
    else $error("item count does not match stack heights");

  a_count_xfer: assert property (@(posedge clk) disable iff (rst)
    (state == mqts_pkg::ST_XFER) |-> (count == in_h + out_h + CW'(1)))
    else $error("item count does not match stack heights during transfer");

  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("item count above capacity");

  a_done_src: assert property (@(posedge clk) disable iff (rst)
    $rose(done) |-> $past(accept || state == mqts_pkg::ST_POP))
    else $error("result without a request or a pending pop");

endmodule

@@ hw/rtl/mqts_stack_ram.sv @@
// Synchronous stack memory with one write port and one registered read port.
module mqts_stack_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, with registered output.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ test/max_queue_two_stack_tb.sv @@
// Self-checking testbench for the two-stack maximum queue, with its own queue predictor.
module max_queue_two_stack_tb;

  localparam int QUEUE_DEPTH = 1024;
  localparam int STALL_LIMIT = 5000;

  // One queued request for the driver; a hold entry makes it wait for every answer.
  typedef struct {
    logic               hold;
    logic [1:0]         act;
    logic signed [31:0] val;
  } request_t;

  // One answer as the block reports it.
  typedef struct {
    logic signed [31:0] data;
    logic               is_empty;
    logic               error;
  } answer_t;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic [1:0]         action;
  logic signed [31:0] value;
  logic               done;
  logic signed [31:0] data;
  logic               is_empty;
  logic               error;

  request_t           pending_requests[$];
  answer_t            owed_answers[$];
  logic signed [31:0] held_items[$];

  logic taken;
  int   stall_cycles;
  int   mismatches;
  int   request_total;
  int   accepted_total;
  int   gen_level;
  int   idle_left;
  int   calm_left;
  int   peak_level;
  int   flagged_errors;
  int   action_seen[4];

  max_queue_two_stack #(
    .DEPTH     (QUEUE_DEPTH),
    .DATA_WIDTH(32)
  ) u_top (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .action  (action),
    .value   (value),
    .done    (done),
    .data    (data),
    .is_empty(is_empty),
    .error   (error)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Reports one mismatch on a line of its own and counts it.
  task automatic report_mismatch(input string what);
    mismatches++;
    $display("MISMATCH @%0t: %s", $time, what);
  endtask

  // Appends a request and keeps track of how full the queue will be.
  task automatic add_request(input logic [1:0] act, input logic signed [31:0] val);
    request_t r;
    r.hold = 1'b0;
    r.act  = act;
    r.val  = val;
    pending_requests.push_back(r);
    request_total++;
    if (act == mqts_pkg::ACT_ENQUEUE && gen_level < QUEUE_DEPTH) gen_level++;
    else if (act == mqts_pkg::ACT_DEQUEUE && gen_level > 0) gen_level--;
  endtask

  // Makes the driver wait until every answer so far has come back.
  task automatic add_hold();
    request_t r;
    r.hold = 1'b1;
    r.act  = mqts_pkg::ACT_EMPTY;
    r.val  = '0;
    pending_requests.push_back(r);
  endtask

  // Random item value: mostly full range, some extremes and some small values for ties.
  function automatic logic signed [31:0] pick_value();
    int sel;
    sel = $urandom_range(0, 9);
    case (sel)
      0: begin
        case ($urandom_range(0, 3))
          0: return 32'sh8000_0000;
          1: return 32'sh7fff_ffff;
          2: return 32'sh0000_0000;
          default: return -32'sd1;
        endcase
      end
      1, 2: return $signed($urandom_range(0, 15)) - 32'sd8;
      default: return $signed($urandom());
    endcase
  endfunction

  // Picks an action from weights given in per cent for enqueue, dequeue and maximum.
  function automatic logic [1:0] pick_action(input int enq_pct, input int deq_pct,
                                              input int max_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < enq_pct) return mqts_pkg::ACT_ENQUEUE;
    if (r < enq_pct + deq_pct) return mqts_pkg::ACT_DEQUEUE;
    if (r < enq_pct + deq_pct + max_pct) return mqts_pkg::ACT_MAXIMUM;
    return mqts_pkg::ACT_EMPTY;
  endfunction

  // Gap before the next request: mostly none, some short, a few long, with calm stretches.
  function automatic int pick_gap();
    int r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 49) == 0) calm_left = $urandom_range(20, 60);
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  // Applies one request to the predicted queue contents and returns the answer it owes.
  function automatic answer_t queue_answer(input logic [1:0] act,
                                           input logic signed [31:0] val);
    answer_t a;
    a.data  = '0;
    a.error = 1'b0;
    case (act)
      mqts_pkg::ACT_ENQUEUE: begin
        if (held_items.size() >= QUEUE_DEPTH) a.error = 1'b1;
        else held_items.push_back(val);
      end
      mqts_pkg::ACT_DEQUEUE: begin
        if (held_items.size() == 0) a.error = 1'b1;
        else a.data = held_items.pop_front();
      end
      mqts_pkg::ACT_MAXIMUM: begin
        if (held_items.size() == 0) begin
          a.error = 1'b1;
        end else begin
          a.data = held_items[0];
          foreach (held_items[i]) if (held_items[i] > a.data) a.data = held_items[i];
        end
      end
      default: ;
    endcase
    a.is_empty = (held_items.size() == 0);
    return a;
  endfunction

  // Driver: presents requests at the falling edge and holds each until it is taken.
  always @(negedge clk) begin : drive
    request_t nxt;
    if (!rst && !(start && !taken)) begin
      if (start) idle_left = pick_gap();
      if (idle_left > 0) begin
        idle_left--;
        start <= 1'b0;
      end else if (pending_requests.size() == 0) begin
        start <= 1'b0;
      end else if (pending_requests[0].hold) begin
        start <= 1'b0;
        if (owed_answers.size() == 0) void'(pending_requests.pop_front());
      end else begin
        nxt = pending_requests.pop_front();
        start  <= 1'b1;
        action <= nxt.act;
        value  <= nxt.val;
      end
    end
  end

  // Monitor: checks answers, predicts taken requests and watches for lack of progress.
  always @(posedge clk) begin : observe
    answer_t want;
    answer_t got;
    if (rst) begin
      taken        <= 1'b0;
      stall_cycles <= 0;
    end else begin
      taken <= start && !busy;
      if (done) begin
        got.data     = data;
        got.is_empty = is_empty;
        got.error    = error;
        if (owed_answers.size() == 0) begin
          report_mismatch($sformatf("answer with none owed: data %0d is_empty %0b error %0b",
                                    got.data, got.is_empty, got.error));
        end else begin
          want = owed_answers.pop_front();
          if (got.data !== want.data)
            report_mismatch($sformatf("data %0d, predicted %0d", got.data, want.data));
          if (got.is_empty !== want.is_empty)
            report_mismatch($sformatf("is_empty %0b, predicted %0b",
                                      got.is_empty, want.is_empty));
          if (got.error !== want.error)
            report_mismatch($sformatf("error %0b, predicted %0b", got.error, want.error));
        end
      end
      if (start && !busy) begin
        want = queue_answer(action, value);
        owed_answers.push_back(want);
        accepted_total++;
        action_seen[action]++;
        if (want.error) flagged_errors++;
        if (held_items.size() > peak_level) peak_level = held_items.size();
      end
      // Any request taken or answer seen counts as progress.
      if (done || (start && !busy)) begin
        stall_cycles <= 0;
      end else if (stall_cycles + 1 >= STALL_LIMIT) begin
        $display("Watchdog: no progress for %0d cycles", STALL_LIMIT);
        $display("DONE: errors detected");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  // Stimulus, reset and end of run.
  initial begin : stimulus
    logic [1:0] act;
    rst = 1'b1;
    start = 1'b0;
    action = mqts_pkg::ACT_ENQUEUE;
    value = '0;
    taken = 1'b0;
    idle_left = 0;
    calm_left = 0;

    // Directed part: empty-queue errors, value extremes, both stacks feeding the maximum.
    add_request(mqts_pkg::ACT_EMPTY,   32'sh1234_5678);
    add_request(mqts_pkg::ACT_DEQUEUE, '0);
    add_request(mqts_pkg::ACT_MAXIMUM, '0);
    add_request(mqts_pkg::ACT_ENQUEUE, 32'sh7fff_ffff);
    add_request(mqts_pkg::ACT_MAXIMUM, '0);
    add_request(mqts_pkg::ACT_ENQUEUE, 32'sh8000_0000);
    add_request(mqts_pkg::ACT_MAXIMUM, '0);
    add_request(mqts_pkg::ACT_EMPTY,   -32'sd1);
    add_request(mqts_pkg::ACT_DEQUEUE, '0);
    add_request(mqts_pkg::ACT_MAXIMUM, '0);
    add_request(mqts_pkg::ACT_ENQUEUE, -32'sd1);
    add_request(mqts_pkg::ACT_MAXIMUM, '0);
    add_request(mqts_pkg::ACT_ENQUEUE, 32'sd0);
    add_request(mqts_pkg::ACT_DEQUEUE, '0);
    add_request(mqts_pkg::ACT_MAXIMUM, '0);
    add_request(mqts_pkg::ACT_DEQUEUE, '0);
    add_request(mqts_pkg::ACT_MAXIMUM, '0);
    add_request(mqts_pkg::ACT_DEQUEUE, '0);
    add_request(mqts_pkg::ACT_EMPTY,   '0);
    add_request(mqts_pkg::ACT_DEQUEUE, 32'shffff_ffff);
    add_request(mqts_pkg::ACT_MAXIMUM, 32'shffff_ffff);
    add_hold();

    // Balanced mix: the queue stays short, so the stacks swap over often.
    repeat (80) begin
      act = pick_action(40, 35, 15);
      add_request(act, pick_value());
    end
    add_hold();

    // Fill to capacity with a few other requests mixed in, then push against the limit.
    while (gen_level < QUEUE_DEPTH) begin
      act = pick_action(94, 2, 3);
      add_request(act, pick_value());
    end
    repeat (3) add_request(mqts_pkg::ACT_ENQUEUE, pick_value());
    add_request(mqts_pkg::ACT_MAXIMUM, '0);
    add_request(mqts_pkg::ACT_EMPTY, '0);
    add_request(mqts_pkg::ACT_ENQUEUE, pick_value());
    add_hold();

    // Mostly dequeues from a full queue.
    repeat (50) begin
      act = pick_action(15, 60, 20);
      add_request(act, pick_value());
    end

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Wait for every request to be taken and answered, then a short tail.
    while (accepted_total < request_total || owed_answers.size() != 0) @(negedge clk);
    repeat (10) @(posedge clk);

    $display("Covered %0d requests: %0d enqueue, %0d dequeue, %0d maximum, %0d empty.",
             accepted_total, action_seen[mqts_pkg::ACT_ENQUEUE],
             action_seen[mqts_pkg::ACT_DEQUEUE], action_seen[mqts_pkg::ACT_MAXIMUM],
             action_seen[mqts_pkg::ACT_EMPTY]);
    $display("%0d requests were flagged as errors; peak occupancy %0d of %0d.",
             flagged_errors, peak_level, QUEUE_DEPTH);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/mqts_pkg.sv
hw/rtl/mqts_stack_ram.sv
hw/rtl/max_queue_two_stack.sv
test/max_queue_two_stack_tb.sv
